// ===== hdl/pobs_pkg.sv =====
// Shared constants, types and arithmetic helpers for the phasor oscillator bank.
// Used by pobs_rotator, pobs_ctrl and the top level; depends on nothing else.
package pobs_pkg;

    // Number of oscillator slots in the bank.
    localparam int MAX_OSC     = 16;
    localparam int IDX_W       = (MAX_OSC > 1) ? $clog2(MAX_OSC) : 1;
    localparam int CNT_W       = $clog2(MAX_OSC + 1);

    localparam int OSC_INDEX_W = 4;
    localparam int CFG_W       = 5;
    localparam int PH_W        = 24;
    localparam int CF_W        = 18;
    localparam int CF_FRAC     = 16;
    localparam int PROD_W      = PH_W + CF_W;
    localparam int PSUM_W      = PROD_W + 2;
    localparam int SHR_W       = PSUM_W - CF_FRAC;
    localparam int SAMPLE_W    = 28;
    localparam int ACC_W       = (PH_W + CNT_W > SAMPLE_W) ? PH_W + CNT_W : SAMPLE_W + 1;

    localparam int PHASE_RAM_W = 2 * PH_W;
    localparam int COEF_RAM_W  = 2 * CF_W;

    // Cycles from the last read issue until its write-back has landed.
    localparam int DRAIN_CYC   = 3;
    localparam int DRAIN_W     = 2;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic             ready;
        logic             start;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             emit;
    } seq_ctl_t;

    // Round a product sum with CF_FRAC extra fraction bits to nearest (half up),
    // then saturate to the phasor width.
    function automatic logic signed [PH_W-1:0] round_q22(input logic signed [PSUM_W-1:0] acc);
        logic signed [PSUM_W-1:0] biased;
        logic signed [SHR_W-1:0]  shr;
        logic signed [SHR_W-1:0]  lim_max;
        logic signed [SHR_W-1:0]  lim_min;
        lim_max = SHR_W'({1'b0, {(PH_W-1){1'b1}}});
        lim_min = -lim_max - SHR_W'(1);
        biased  = acc + PSUM_W'(1 << (CF_FRAC - 1));
        shr     = biased[PSUM_W-1:CF_FRAC];
        if (shr > lim_max) begin
            return {1'b0, {(PH_W-1){1'b1}}};
        end else if (shr < lim_min) begin
            return {1'b1, {(PH_W-1){1'b0}}};
        end else begin
            return shr[PH_W-1:0];
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] lim_max;
        logic signed [ACC_W-1:0] lim_min;
        lim_max = ACC_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
        lim_min = -lim_max - ACC_W'(1);
        if (acc > lim_max) begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (acc < lim_min) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return acc[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/pobs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module pobs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/pobs_rotator.sv =====
// Two-stage complex rotator: four registered products, then the sums rounded and saturated.
// Depends on pobs_pkg.
module pobs_rotator
    import pobs_pkg::*;
(
    input  logic                   aclk,
    input  logic signed [PH_W-1:0] re_in,
    input  logic signed [PH_W-1:0] im_in,
    input  logic signed [CF_W-1:0] cos_in,
    input  logic signed [CF_W-1:0] sin_in,
    output logic signed [PH_W-1:0] re_out,
    output logic signed [PH_W-1:0] im_out
);

    logic signed [PROD_W-1:0] p_rc_reg;
    logic signed [PROD_W-1:0] p_is_reg;
    logic signed [PROD_W-1:0] p_rs_reg;
    logic signed [PROD_W-1:0] p_ic_reg;
    logic signed [PH_W-1:0]   re_reg;
    logic signed [PH_W-1:0]   im_reg;
    logic signed [PSUM_W-1:0] re_sum;
    logic signed [PSUM_W-1:0] im_sum;

    always_ff @(posedge aclk) begin
        p_rc_reg <= re_in * cos_in;
        p_is_reg <= im_in * sin_in;
        p_rs_reg <= re_in * sin_in;
        p_ic_reg <= im_in * cos_in;
    end

    assign re_sum = PSUM_W'(p_rc_reg) - PSUM_W'(p_is_reg);
    assign im_sum = PSUM_W'(p_rs_reg) + PSUM_W'(p_ic_reg);

    always_ff @(posedge aclk) begin
        re_reg <= round_q22(re_sum);
        im_reg <= round_q22(im_sum);
    end

    assign re_out = re_reg;
    assign im_out = im_reg;

endmodule

// ===== hdl/pobs_ctrl.sv =====
// Tick sequencer: walks the active slots one per cycle, waits for write-back, emits the sample.
// Depends on pobs_pkg.
module pobs_ctrl
    import pobs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_opcode,
    input  logic [CFG_W-1:0] active_count,
    input  logic             out_free,
    output seq_ctl_t         ctl
);

    seq_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;
    logic [CNT_W-1:0]   n_eff;
    logic               tick_acc;
    logic               last_rd;
    logic               drain_done;

    // A count of zero behaves as one; a count above the bank size is clipped.
    always_comb begin
        if (active_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (int'(active_count) > MAX_OSC) begin
            n_eff = CNT_W'(MAX_OSC);
        end else begin
            n_eff = CNT_W'(active_count);
        end
    end

    assign tick_acc   = (state_reg == ST_IDLE) && s_valid && (opcode_t'(s_opcode) == OP_TICK);
    assign last_rd    = (k_reg + CNT_W'(1)) == n_reg;
    assign drain_done = drain_reg == DRAIN_W'(DRAIN_CYC - 1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (tick_acc) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (last_rd) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl.ready   = 1'b0;
        ctl.start   = 1'b0;
        ctl.rd_en   = 1'b0;
        ctl.rd_addr = k_reg[IDX_W-1:0];
        ctl.emit    = 1'b0;
        k_next      = k_reg;
        n_next      = n_reg;
        drain_next  = drain_reg;
        case (state_reg)
            ST_IDLE: begin
                ctl.ready = 1'b1;
                ctl.start = tick_acc;
                if (tick_acc) begin
                    k_next = '0;
                    n_next = n_eff;
                end
            end
            ST_READ: begin
                ctl.rd_en  = 1'b1;
                k_next     = k_reg + CNT_W'(1);
                drain_next = '0;
            end
            ST_DRAIN: begin
                drain_next = drain_reg + DRAIN_W'(1);
            end
            ST_EMIT: begin
                ctl.emit = out_free;
            end
            default: begin
                ctl.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            n_reg     <= CNT_W'(1);
            drain_reg <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            drain_reg <= drain_next;
        end
    end

endmodule

// ===== hdl/phasor_oscillator_bank_sum.sv =====
// Phasor oscillator bank top level; uses pobs_pkg, pobs_ram, pobs_rotator and pobs_ctrl.
// A load item is written straight into the slot RAMs when it is taken. A tick reads one slot
// per cycle into a rotate/write-back pipeline (RAM read, product and rounding registers): its
// sample is registered once the pipeline has drained, and the next item is taken after that,
// later while the output register still holds an unaccepted sample. Synchronous active-low
// reset clears the per-slot valid bits (all slots read as zero), sets the active count to 1, empties the output.
module phasor_oscillator_bank_sum
    import pobs_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_W-1:0]              cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [OSC_INDEX_W-1:0]        s_osc_index,
    input  logic signed [CF_W-1:0]        s_cos_coef,
    input  logic signed [CF_W-1:0]        s_sin_coef,
    input  logic signed [PH_W-1:0]        s_amplitude,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_W-1:0]    m_sample
);

    seq_ctl_t                   ctl;
    logic [CFG_W-1:0]           active_count_reg;
    logic [MAX_OSC-1:0]         slot_vld_reg, slot_vld_next;
    logic                       load_we;
    logic                       out_free;

    logic                       rd_vld_d1_reg;
    logic                       ent_vld_d1_reg;
    logic [IDX_W-1:0]           addr_d1_reg;
    logic                       prod_vld_reg;
    logic [IDX_W-1:0]           addr_d2_reg;
    logic                       wb_vld_reg;
    logic [IDX_W-1:0]           addr_d3_reg;

    logic                       ph_we;
    logic [IDX_W-1:0]           ph_waddr;
    logic [PHASE_RAM_W-1:0]     ph_wdata;
    logic [PHASE_RAM_W-1:0]     ph_rdata;
    logic [COEF_RAM_W-1:0]      cf_rdata;

    logic signed [PH_W-1:0]     re_rd;
    logic signed [PH_W-1:0]     im_rd;
    logic signed [CF_W-1:0]     cos_rd;
    logic signed [CF_W-1:0]     sin_rd;
    logic signed [PH_W-1:0]     re_new;
    logic signed [PH_W-1:0]     im_new;

    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] m_sample_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = ctl.ready;

    pobs_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_opcode     (s_opcode),
        .active_count (active_count_reg),
        .out_free     (out_free),
        .ctl          (ctl)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_count_reg <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            active_count_reg <= cfg_wr_data;
        end
    end

    // Loads to a slot beyond the bank are dropped.
    assign load_we = s_valid && ctl.ready && (opcode_t'(s_opcode) == OP_LOAD)
                     && (int'(s_osc_index) < MAX_OSC);

    always_comb begin
        slot_vld_next = slot_vld_reg;
        if (load_we) begin
            slot_vld_next[IDX_W'(s_osc_index)] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_vld_reg <= '0;
        end else begin
            slot_vld_reg <= slot_vld_next;
        end
    end

    // Write-back and loads never coincide: loads are taken only after the pipeline drains.
    assign ph_we    = load_we || wb_vld_reg;
    assign ph_waddr = wb_vld_reg ? addr_d3_reg : IDX_W'(s_osc_index);
    assign ph_wdata = wb_vld_reg ? {re_new, im_new} : {s_amplitude, {PH_W{1'b0}}};

    pobs_ram #(
        .WIDTH (PHASE_RAM_W),
        .DEPTH (MAX_OSC)
    ) u_phase_ram (
        .aclk    (aclk),
        .wr_en   (ph_we),
        .wr_addr (ph_waddr),
        .wr_data (ph_wdata),
        .rd_en   (ctl.rd_en),
        .rd_addr (ctl.rd_addr),
        .rd_data (ph_rdata)
    );

    pobs_ram #(
        .WIDTH (COEF_RAM_W),
        .DEPTH (MAX_OSC)
    ) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (load_we),
        .wr_addr (IDX_W'(s_osc_index)),
        .wr_data ({s_cos_coef, s_sin_coef}),
        .rd_en   (ctl.rd_en),
        .rd_addr (ctl.rd_addr),
        .rd_data (cf_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_d1_reg <= 1'b0;
            prod_vld_reg  <= 1'b0;
            wb_vld_reg    <= 1'b0;
        end else begin
            rd_vld_d1_reg <= ctl.rd_en;
            prod_vld_reg  <= rd_vld_d1_reg;
            wb_vld_reg    <= prod_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ent_vld_d1_reg <= slot_vld_reg[ctl.rd_addr];
        addr_d1_reg    <= ctl.rd_addr;
        addr_d2_reg    <= addr_d1_reg;
        addr_d3_reg    <= addr_d2_reg;
    end

    // A slot never loaded since reset reads as all zero.
    assign re_rd  = ent_vld_d1_reg ? ph_rdata[PHASE_RAM_W-1:PH_W] : '0;
    assign im_rd  = ent_vld_d1_reg ? ph_rdata[PH_W-1:0]           : '0;
    assign cos_rd = ent_vld_d1_reg ? cf_rdata[COEF_RAM_W-1:CF_W]  : '0;
    assign sin_rd = ent_vld_d1_reg ? cf_rdata[CF_W-1:0]           : '0;

    pobs_rotator u_rotator (
        .aclk   (aclk),
        .re_in  (re_rd),
        .im_in  (im_rd),
        .cos_in (cos_rd),
        .sin_in (sin_rd),
        .re_out (re_new),
        .im_out (im_new)
    );

    always_comb begin
        acc_next = acc_reg;
        if (ctl.start) begin
            acc_next = '0;
        end else if (rd_vld_d1_reg) begin
            acc_next = acc_reg + ACC_W'(re_rd);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            m_sample_reg <= sat_sample(acc_reg);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    a_no_wb_load_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_vld_reg |-> !load_we)
        else $error("load collides with phasor write-back");

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ready |-> !(rd_vld_d1_reg || prod_vld_reg || wb_vld_reg))
        else $error("block ready while rotation pipeline busy");

    a_emit_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit |-> !(ctl.rd_en || rd_vld_d1_reg || prod_vld_reg || wb_vld_reg))
        else $error("sample emitted before the sum is complete");

    a_start_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |=> ctl.rd_en && (ctl.rd_addr == '0))
        else $error("tick did not start reading at slot zero");

endmodule
